// ----- rtl/rmypr_pkg.sv -----
// Shared types, constants and CORDIC helper functions for the yaw/pitch/roll converter.
`default_nettype none
package rmypr_pkg;

  localparam int CORDIC_ITERATIONS = 16;
  localparam int ATAN_LEN = 24;
  localparam int NITER = (CORDIC_ITERATIONS < ATAN_LEN) ? CORDIC_ITERATIONS : ATAN_LEN;

  localparam int IN_W  = 16;
  localparam int VEC_W = 36;
  localparam int ANG_W = 28;
  localparam int OUT_W = 16;
  localparam int INV_GAIN_Q16 = 39797;
  localparam int PROD_W = VEC_W + 17;

  typedef logic signed [IN_W-1:0]  in_t;
  typedef logic signed [VEC_W-1:0] vec_t;
  typedef logic signed [ANG_W-1:0] ang_t;
  typedef logic signed [OUT_W-1:0] out_t;

  localparam ang_t ANGLE_PI = ang_t'(52707179);
  localparam out_t OUT_PI   = out_t'(25736);

  typedef ang_t atan_tab_t [ATAN_LEN];
  localparam atan_tab_t ATAN_TAB = '{
    ang_t'(13176795), ang_t'(7778716), ang_t'(4110060), ang_t'(2086331),
    ang_t'(1047214),  ang_t'(524117),  ang_t'(262123),  ang_t'(131069),
    ang_t'(65536),    ang_t'(32768),   ang_t'(16384),   ang_t'(8192),
    ang_t'(4096),     ang_t'(2048),    ang_t'(1024),    ang_t'(512),
    ang_t'(256),      ang_t'(128),     ang_t'(64),      ang_t'(32),
    ang_t'(16),       ang_t'(8),       ang_t'(4),       ang_t'(2)
  };

  // Classified matrix item passed from the front end to the CORDIC pipeline.
  typedef struct packed {
    logic zero;
    vec_t x;
    vec_t y;
    ang_t z;
    vec_t c2x;
    vec_t c2y;
    vec_t c1x;
    vec_t c1y;
    vec_t nz;
  } item_t;

  // One vectoring CORDIC in flight.
  typedef struct packed {
    logic zero;
    vec_t x;
    vec_t y;
    ang_t z;
  } cv_t;

  typedef struct packed {
    vec_t x;
    vec_t y;
  } pair_t;

  function automatic vec_t widen(input in_t v);
    widen = {{(VEC_W-IN_W-16){v[IN_W-1]}}, v, 16'h0000};
  endfunction

  // Micro-rotation of one vector; up means the driving y was non-negative.
  function automatic pair_t rot(input vec_t cx, input vec_t cy, input logic up, input int i);
    pair_t p;
    if (up) begin
      p.x = cx + (cy >>> i);
      p.y = cy - (cx >>> i);
    end else begin
      p.x = cx - (cy >>> i);
      p.y = cy + (cx >>> i);
    end
    rot = p;
  endfunction

  // Zero detection and left half-plane fold ahead of a vectoring run.
  function automatic cv_t cv_pre(input vec_t x, input vec_t y);
    cv_t c;
    c.zero = (x == '0) && (y == '0);
    c.x = x;
    c.y = y;
    c.z = '0;
    if (!c.zero && x[VEC_W-1]) begin
      c.x = -x;
      c.y = -y;
      c.z = y[VEC_W-1] ? -ANGLE_PI : ANGLE_PI;
    end
    cv_pre = c;
  endfunction

  function automatic cv_t cv_iter(input cv_t c, input int i);
    cv_t o;
    pair_t p;
    logic up;
    o = c;
    up = !c.y[VEC_W-1];
    p = rot(c.x, c.y, up, i);
    if (!c.zero) begin
      o.x = p.x;
      o.y = p.y;
      o.z = up ? c.z + ATAN_TAB[i] : c.z - ATAN_TAB[i];
    end
    cv_iter = o;
  endfunction

  // Round half up to Q3.13 and clamp to plus or minus pi.
  function automatic out_t to_q13(input ang_t z);
    logic signed [ANG_W:0] s;
    logic signed [ANG_W-11:0] r;
    s = {z[ANG_W-1], z} + (ANG_W+1)'(1024);
    r = s[ANG_W:11];
    if (r > (ANG_W-10)'(OUT_PI)) to_q13 = OUT_PI;
    else if (r < -(ANG_W-10)'(OUT_PI)) to_q13 = -OUT_PI;
    else to_q13 = r[OUT_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/rmypr_if.sv -----
// Valid/ready channel interfaces for matrix items and angle results.
`default_nettype none
interface rmypr_in_if;
  logic valid;
  logic ready;
  rmypr_pkg::in_t col0_x;
  rmypr_pkg::in_t col0_y;
  rmypr_pkg::in_t col0_z;
  rmypr_pkg::in_t col1_x;
  rmypr_pkg::in_t col1_y;
  rmypr_pkg::in_t col2_x;
  rmypr_pkg::in_t col2_y;
  modport source (output valid, col0_x, col0_y, col0_z, col1_x, col1_y, col2_x, col2_y,
                  input ready);
  modport sink (input valid, col0_x, col0_y, col0_z, col1_x, col1_y, col2_x, col2_y,
                output ready);
endinterface

interface rmypr_out_if;
  logic valid;
  logic ready;
  rmypr_pkg::out_t yaw_angle;
  rmypr_pkg::out_t pitch_angle;
  rmypr_pkg::out_t roll_angle;
  modport source (output valid, yaw_angle, pitch_angle, roll_angle, input ready);
  modport sink (input valid, yaw_angle, pitch_angle, roll_angle, output ready);
endinterface
`default_nettype wire

// ----- rtl/rmypr_front.sv -----
// Front end: accepts matrix items, scales them and folds the yaw vector into the right half-plane.
`default_nettype none
module rmypr_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  rmypr_in_if.sink             in_ch,
  output rmypr_pkg::item_t     item,
  output logic                 item_valid,
  input  wire logic            item_ready
);

  logic             vld_r;
  logic             vld_nxt;
  rmypr_pkg::item_t item_r;
  rmypr_pkg::item_t item_nxt;
  rmypr_pkg::cv_t   cv;
  logic             take;

  assign in_ch.ready = !vld_r || item_ready;
  assign take = in_ch.valid && in_ch.ready;

  always_comb begin
    cv = rmypr_pkg::cv_pre(rmypr_pkg::widen(in_ch.col0_x), rmypr_pkg::widen(in_ch.col0_y));
    item_nxt.zero = cv.zero;
    item_nxt.x = cv.x;
    item_nxt.y = cv.y;
    item_nxt.z = cv.z;
    item_nxt.c2x = rmypr_pkg::widen(in_ch.col2_x);
    item_nxt.c2y = rmypr_pkg::widen(in_ch.col2_y);
    item_nxt.c1x = rmypr_pkg::widen(in_ch.col1_x);
    item_nxt.c1y = rmypr_pkg::widen(in_ch.col1_y);
    item_nxt.nz = rmypr_pkg::widen(in_ch.col0_z);
    // The companions turn with the yaw vector when it is folded by pi.
    if (!cv.zero && in_ch.col0_x[rmypr_pkg::IN_W-1]) begin
      item_nxt.c2x = -item_nxt.c2x;
      item_nxt.c2y = -item_nxt.c2y;
      item_nxt.c1x = -item_nxt.c1x;
      item_nxt.c1y = -item_nxt.c1y;
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (take) vld_nxt = 1'b1;
    else if (item_ready) vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else vld_r <= vld_nxt;
  end

  always_ff @(posedge clk) begin
    if (take) item_r <= item_nxt;
  end

  assign item = item_r;
  assign item_valid = vld_r;

endmodule
`default_nettype wire

// ----- rtl/rmypr_queue.sv -----
// Two-entry queue between the front end and the CORDIC pipeline.
`default_nettype none
module rmypr_queue (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire rmypr_pkg::item_t wr_item,
  input  wire logic         wr_valid,
  output logic              wr_ready,
  output rmypr_pkg::item_t  rd_item,
  output logic              rd_valid,
  input  wire logic         rd_ready
);

  localparam int DEPTH = 2;

  rmypr_pkg::item_t mem [DEPTH];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       push;
  logic       pop;

  assign wr_ready = (cnt_r != 2'(DEPTH));
  assign rd_valid = (cnt_r != 2'd0);
  assign push = wr_valid && wr_ready;
  assign pop = rd_valid && rd_ready;
  assign rd_item = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= wr_item;
  end

endmodule
`default_nettype wire

// ----- rtl/rmypr_back.sv -----
// Back end: pipelined yaw CORDIC, pitch scaling, pitch and roll CORDICs and output register.
`default_nettype none
module rmypr_back (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire rmypr_pkg::item_t item,
  input  wire logic         item_valid,
  output logic              item_ready,
  rmypr_out_if.source       out_ch
);

  localparam int N = rmypr_pkg::NITER;

  typedef struct packed {
    logic             vld;
    rmypr_pkg::item_t it;
  } ys_t;

  typedef struct packed {
    logic            vld;
    rmypr_pkg::ang_t yaw;
    rmypr_pkg::vec_t hx;
    rmypr_pkg::vec_t hy;
    rmypr_pkg::vec_t rx;
    rmypr_pkg::vec_t ry;
  } ms_t;

  typedef struct packed {
    logic            vld;
    rmypr_pkg::ang_t yaw;
    rmypr_pkg::cv_t  p;
    rmypr_pkg::cv_t  r;
  } ps_t;

  typedef struct packed {
    logic            vld;
    rmypr_pkg::out_t yaw;
    rmypr_pkg::out_t pitch;
    rmypr_pkg::out_t roll;
  } fin_t;

  ys_t  ys_r [N+1];
  ys_t  ys_nxt [N+1];
  ms_t  ms_r;
  ms_t  ms_nxt;
  ps_t  ps_r [N+1];
  ps_t  ps_nxt [N+1];
  fin_t fin_r;
  fin_t fin_nxt;
  logic en;
  logic signed [rmypr_pkg::PROD_W-1:0] prod;

  assign en = !fin_r.vld || out_ch.ready;
  assign item_ready = en;

  always_comb begin
    rmypr_pkg::cv_t cv;
    rmypr_pkg::pair_t c2;
    rmypr_pkg::pair_t c1;
    logic up;
    ys_nxt[0].vld = item_valid;
    ys_nxt[0].it = item;
    for (int k = 1; k <= N; k++) begin
      ys_nxt[k] = ys_r[k-1];
      cv.zero = ys_r[k-1].it.zero;
      cv.x = ys_r[k-1].it.x;
      cv.y = ys_r[k-1].it.y;
      cv.z = ys_r[k-1].it.z;
      up = !cv.y[rmypr_pkg::VEC_W-1];
      cv = rmypr_pkg::cv_iter(cv, k-1);
      c2 = rmypr_pkg::rot(ys_r[k-1].it.c2x, ys_r[k-1].it.c2y, up, k-1);
      c1 = rmypr_pkg::rot(ys_r[k-1].it.c1x, ys_r[k-1].it.c1y, up, k-1);
      ys_nxt[k].it.x = cv.x;
      ys_nxt[k].it.y = cv.y;
      ys_nxt[k].it.z = cv.z;
      if (!ys_r[k-1].it.zero) begin
        ys_nxt[k].it.c2x = c2.x;
        ys_nxt[k].it.c2y = c2.y;
        ys_nxt[k].it.c1x = c1.x;
        ys_nxt[k].it.c1y = c1.y;
      end
    end
  end

  // Pitch denominator: the yaw CORDIC's x scaled by the inverse CORDIC gain.
  always_comb begin
    prod = $signed({{(rmypr_pkg::PROD_W-rmypr_pkg::VEC_W){ys_r[N].it.x[rmypr_pkg::VEC_W-1]}},
                    ys_r[N].it.x}) * $signed(rmypr_pkg::PROD_W'(rmypr_pkg::INV_GAIN_Q16));
    ms_nxt.vld = ys_r[N].vld;
    ms_nxt.yaw = ys_r[N].it.z;
    ms_nxt.hx = ys_r[N].it.zero ? '0 : prod[rmypr_pkg::VEC_W+15:16];
    ms_nxt.hy = -ys_r[N].it.nz;
    ms_nxt.rx = ys_r[N].it.c1y;
    ms_nxt.ry = -ys_r[N].it.c2y;
  end

  always_comb begin
    ps_nxt[0].vld = ms_r.vld;
    ps_nxt[0].yaw = ms_r.yaw;
    ps_nxt[0].p = rmypr_pkg::cv_pre(ms_r.hx, ms_r.hy);
    ps_nxt[0].r = rmypr_pkg::cv_pre(ms_r.rx, ms_r.ry);
    for (int k = 1; k <= N; k++) begin
      ps_nxt[k].vld = ps_r[k-1].vld;
      ps_nxt[k].yaw = ps_r[k-1].yaw;
      ps_nxt[k].p = rmypr_pkg::cv_iter(ps_r[k-1].p, k-1);
      ps_nxt[k].r = rmypr_pkg::cv_iter(ps_r[k-1].r, k-1);
    end
    fin_nxt.vld = ps_r[N].vld;
    fin_nxt.yaw = rmypr_pkg::to_q13(ps_r[N].yaw);
    fin_nxt.pitch = rmypr_pkg::to_q13(ps_r[N].p.z);
    fin_nxt.roll = rmypr_pkg::to_q13(ps_r[N].r.z);
  end

  // Reset clears only the valid bits; payloads load whenever the pipeline advances.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= N; k++) begin
        ys_r[k].vld <= 1'b0;
        ps_r[k].vld <= 1'b0;
      end
      ms_r.vld <= 1'b0;
      fin_r.vld <= 1'b0;
    end else if (en) begin
      for (int k = 0; k <= N; k++) begin
        ys_r[k] <= ys_nxt[k];
        ps_r[k] <= ps_nxt[k];
      end
      ms_r <= ms_nxt;
      fin_r <= fin_nxt;
    end
  end

  assign out_ch.valid = fin_r.vld;
  assign out_ch.yaw_angle = fin_r.yaw;
  assign out_ch.pitch_angle = fin_r.pitch;
  assign out_ch.roll_angle = fin_r.roll;

endmodule
`default_nettype wire

// ----- rtl/rotation_matrix_to_yaw_pitch_roll.sv -----
// Top level of the rotation matrix to ZYX yaw/pitch/roll converter.
//
//   Channel  Direction  Payload                                           Handshake
//   in_ch    sink       col0_x col0_y col0_z col1_x col1_y col2_x col2_y  valid/ready
//   out_ch   source     yaw_angle pitch_angle roll_angle                  valid/ready
//
// One transaction is accepted per cycle and one result leaves per cycle when the sink keeps up.
// From input acceptance to output acceptance an item passes, in order, through the front
// register, queue entry, pipeline input register, yaw CORDIC stages, gain multiply, fold
// stage, pitch/roll CORDIC stages and output register.
// Reset (rst_n low, synchronous) empties all stages; no clearing pass is needed.
// A stalled result holds the pipeline; the front end and queue keep taking items until full.
`default_nettype none
module rotation_matrix_to_yaw_pitch_roll (
  input wire logic     clk,
  input wire logic     rst_n,
  rmypr_in_if.sink     in_ch,
  rmypr_out_if.source  out_ch
);

  // Front end output: scaled and folded item waiting to enter the queue.
  rmypr_pkg::item_t f_item;
  logic             f_valid;
  logic             f_ready;

  // Queue output feeding the CORDIC pipeline.
  rmypr_pkg::item_t q_item;
  logic             q_valid;
  logic             q_ready;

  rmypr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .item       (f_item),
    .item_valid (f_valid),
    .item_ready (f_ready)
  );

  rmypr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_item  (f_item),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .rd_item  (q_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready)
  );

  // The back end advances all of its stages together whenever its output can move.
  rmypr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (q_item),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .out_ch     (out_ch)
  );

endmodule
`default_nettype wire

// ----- rtl/rmypr_checker.sv -----
// Port-level assertions for the converter, bound to the top level.
`default_nettype none
module rmypr_checker (
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            out_valid,
  input wire logic            out_ready,
  input wire rmypr_pkg::out_t yaw_angle,
  input wire rmypr_pkg::out_t pitch_angle,
  input wire rmypr_pkg::out_t roll_angle
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(yaw_angle) && $stable(pitch_angle)
                                && $stable(roll_angle))
    else $error("result changed while stalled");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> yaw_angle <= rmypr_pkg::OUT_PI && yaw_angle >= -rmypr_pkg::OUT_PI
               && pitch_angle <= rmypr_pkg::OUT_PI && pitch_angle >= -rmypr_pkg::OUT_PI
               && roll_angle <= rmypr_pkg::OUT_PI && roll_angle >= -rmypr_pkg::OUT_PI)
    else $error("angle outside saturation range");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind rotation_matrix_to_yaw_pitch_roll rmypr_checker u_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .yaw_angle   (out_ch.yaw_angle),
  .pitch_angle (out_ch.pitch_angle),
  .roll_angle  (out_ch.roll_angle)
);
`default_nettype wire

// ----- sim/rmypr_test_if.sv -----
// Angle constants and arctangent table for the testbench's predictor, written out independently.
`timescale 1ns / 1ps
`default_nettype none
package rmypr_test_pkg;

  // Angles are in rad * 2^24; the output clamp ROT_CLAMP is in rad * 2^13.
  localparam longint PI_Z = 52707179;
  localparam longint GAIN_INV = 39797;
  localparam longint ROT_CLAMP = 25736;
  localparam longint ARC [24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
    262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
    16, 8, 4, 2};

endpackage
`default_nettype wire

// ----- sim/rotation_matrix_to_yaw_pitch_roll_test.sv -----
// Testbench for the rotation matrix to yaw/pitch/roll converter with its own angle predictor.
`timescale 1ns / 1ps
`default_nettype none
module rotation_matrix_to_yaw_pitch_roll_test;

  typedef rmypr_pkg::in_t in_t;
  typedef rmypr_pkg::out_t out_t;

  // One matrix transaction: the seven entries in port order.
  typedef struct {
    in_t c0x, c0y, c0z, c1x, c1y, c2x, c2y;
  } matrix_t;

  // One angle triple as the block returns it.
  typedef struct {
    out_t yaw, pitch, roll;
  } angles_t;

  localparam int CORDIC_ITERATIONS = rmypr_pkg::CORDIC_ITERATIONS;
  localparam int PIPE_CYCLES = 2 * CORDIC_ITERATIONS + 6;
  localparam int STALL_LIMIT = 5000;
  localparam int N_RANDOM = 1600;

  // The scoreboard predicts an angle triple for every accepted matrix and holds them in order.
  class angle_scoreboard;
    angles_t pending[$];
    int errors;

    // Vectoring CORDIC: drives (x, y) to the x axis, rotates ncomp companion pairs with it.
    function automatic longint vector_angle(ref longint x, ref longint y,
                                             ref longint comp[4], input int ncomp);
      longint z, tx, cx, cy;
      bit up;
      int steps;
      z = 0;
      steps = (CORDIC_ITERATIONS < 24) ? CORDIC_ITERATIONS : 24;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        // Left half-plane: fold by pi and start the angle at plus or minus pi.
        z = (y >= 0) ? rmypr_test_pkg::PI_Z : -rmypr_test_pkg::PI_Z;
        x = -x;
        y = -y;
        for (int k = 0; k < 2 * ncomp; k++) comp[k] = -comp[k];
      end
      for (int i = 0; i < steps; i++) begin
        up = (y >= 0);
        tx = x;
        if (up) begin
          x = x + (y >>> i);
          y = y - (tx >>> i);
          z = z + rmypr_test_pkg::ARC[i];
        end else begin
          x = x - (y >>> i);
          y = y + (tx >>> i);
          z = z - rmypr_test_pkg::ARC[i];
        end
        for (int k = 0; k < ncomp; k++) begin
          cx = comp[2*k];
          cy = comp[2*k+1];
          comp[2*k]   = up ? cx + (cy >>> i) : cx - (cy >>> i);
          comp[2*k+1] = up ? cy - (cx >>> i) : cy + (cx >>> i);
        end
      end
      return z;
    endfunction

    // Round half up to Q3.13 radians and clamp to plus or minus pi.
    function automatic out_t round_angle(longint z);
      longint r;
      r = (z + 1024) >>> 11;
      if (r > rmypr_test_pkg::ROT_CLAMP) r = rmypr_test_pkg::ROT_CLAMP;
      if (r < -rmypr_test_pkg::ROT_CLAMP) r = -rmypr_test_pkg::ROT_CLAMP;
      return out_t'(r);
    endfunction

    function void note_matrix(matrix_t m);
      longint nx, ny, hx, hy, rx, ry;
      longint comp[4];
      longint dummy[4];
      angles_t a;
      nx = longint'(m.c0x) * 65536;
      ny = longint'(m.c0y) * 65536;
      comp[0] = longint'(m.c2x) * 65536;
      comp[1] = longint'(m.c2y) * 65536;
      comp[2] = longint'(m.c1x) * 65536;
      comp[3] = longint'(m.c1y) * 65536;
      dummy = '{0, 0, 0, 0};
      if (nx == 0 && ny == 0) begin
        // Gimbal lock: no yaw rotation, pitch denominator zero.
        a.yaw = 0;
        hx = 0;
      end else begin
        a.yaw = round_angle(vector_angle(nx, ny, comp, 2));
        hx = (nx * rmypr_test_pkg::GAIN_INV) >>> 16;
      end
      hy = -(longint'(m.c0z) * 65536);
      a.pitch = round_angle(vector_angle(hx, hy, dummy, 0));
      rx = comp[3];
      ry = -comp[1];
      a.roll = round_angle(vector_angle(rx, ry, dummy, 0));
      pending = {pending, a};
    endfunction

    function void check_angles(angles_t got);
      angles_t exp_a;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result yaw=%0d pitch=%0d roll=%0d", $time,
                 got.yaw, got.pitch, got.roll);
        errors++;
        return;
      end
      exp_a = pending.pop_front();
      if (got.yaw !== exp_a.yaw) begin
        $display("%0t: yaw mismatch expected %0d actual %0d", $time, exp_a.yaw, got.yaw);
        errors++;
      end
      if (got.pitch !== exp_a.pitch) begin
        $display("%0t: pitch mismatch expected %0d actual %0d", $time, exp_a.pitch, got.pitch);
        errors++;
      end
      if (got.roll !== exp_a.roll) begin
        $display("%0t: roll mismatch expected %0d actual %0d", $time, exp_a.roll, got.roll);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  rmypr_in_if in_ch ();
  rmypr_out_if out_ch ();

  rotation_matrix_to_yaw_pitch_roll dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  angle_scoreboard board;
  matrix_t directed_set[$];
  bit sending_done;
  bit hold_off_request;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void add_directed(matrix_t m);
    directed_set = {directed_set, m};
  endfunction

  // Drive one matrix and keep it up until the block takes it.
  task automatic send_matrix(matrix_t m, bit allow_gap);
    int gap;
    gap = allow_gap ? $urandom_range(0, 5) : 0;
    repeat (gap) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.col0_x <= m.c0x;
    in_ch.col0_y <= m.c0y;
    in_ch.col0_z <= m.c0z;
    in_ch.col1_x <= m.c1x;
    in_ch.col1_y <= m.c1y;
    in_ch.col2_x <= m.c2x;
    in_ch.col2_y <= m.c2y;
    do @(posedge clk); while (!in_ch.ready);
    board.note_matrix(m);
    @(negedge clk);
  endtask

  function automatic in_t rand_entry();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: return in_t'(0);
      1: return in_t'(16384);
      2: return in_t'(-16384);
      3: return in_t'(16'h8000);
      4: return in_t'(16'h7fff);
      5: return in_t'($urandom_range(0, 15)) - in_t'(8);
      default: return in_t'($urandom());
    endcase
  endfunction

  // A rotation from random Euler angles, occasionally with one entry disturbed.
  function automatic matrix_t rand_rotation();
    matrix_t m;
    real y, p, r, cy, sy, cp, sp, cr, sr;
    y = ($urandom_range(0, 65535) / 65535.0 * 2.0 - 1.0) * 3.14159265;
    p = ($urandom_range(0, 65535) / 65535.0 * 2.0 - 1.0) * 1.5707963;
    r = ($urandom_range(0, 65535) / 65535.0 * 2.0 - 1.0) * 3.14159265;
    cy = $cos(y); sy = $sin(y); cp = $cos(p); sp = $sin(p); cr = $cos(r); sr = $sin(r);
    m.c0x = in_t'($rtoi(cy * cp * 16384.0));
    m.c0y = in_t'($rtoi(sy * cp * 16384.0));
    m.c0z = in_t'($rtoi(-sp * 16384.0));
    m.c1x = in_t'($rtoi((cy * sp * sr - sy * cr) * 16384.0));
    m.c1y = in_t'($rtoi((sy * sp * sr + cy * cr) * 16384.0));
    m.c2x = in_t'($rtoi((cy * sp * cr + sy * sr) * 16384.0));
    m.c2y = in_t'($rtoi((sy * sp * cr - cy * sr) * 16384.0));
    if ($urandom_range(0, 7) == 0) m.c0z = rand_entry();
    return m;
  endfunction

  function automatic matrix_t rand_noise();
    matrix_t m;
    m.c0x = rand_entry(); m.c0y = rand_entry(); m.c0z = rand_entry();
    m.c1x = rand_entry(); m.c1y = rand_entry(); m.c2x = rand_entry(); m.c2y = rand_entry();
    return m;
  endfunction

  function automatic matrix_t mk(int a, int b, int c, int d, int e, int f, int g);
    matrix_t m;
    m.c0x = in_t'(a); m.c0y = in_t'(b); m.c0z = in_t'(c);
    m.c1x = in_t'(d); m.c1y = in_t'(e); m.c2x = in_t'(f); m.c2y = in_t'(g);
    return m;
  endfunction

  // Sender: directed cases, then random matrices, each with a random gap ahead of it.
  initial begin
    board = new();
    sending_done = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.col0_x = '0; in_ch.col0_y = '0; in_ch.col0_z = '0;
    in_ch.col1_x = '0; in_ch.col1_y = '0; in_ch.col2_x = '0; in_ch.col2_y = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // Identity, half-plane folds on the pi boundary, gimbal lock and field extremes.
    add_directed(mk(16384, 0, 0, 0, 16384, 0, 0));
    add_directed(mk(-16384, 0, 0, 0, -16384, 0, 0));
    add_directed(mk(-16384, -1, 0, 1, -16384, 0, 0));
    add_directed(mk(0, 16384, 0, -16384, 0, 0, 0));
    add_directed(mk(0, -16384, 0, 16384, 0, 0, 0));
    add_directed(mk(0, 0, -16384, 0, 16384, 16384, 0));
    add_directed(mk(0, 0, 16384, 0, 16384, -16384, 0));
    add_directed(mk(0, 0, 0, 0, 0, 0, 0));
    add_directed(mk(0, 0, 0, 0, -16384, 0, 16384));
    add_directed(mk(0, 0, 0, 0, -1, 0, -1));
    add_directed(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767));
    add_directed(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
    add_directed(mk(-32768, 0, 32767, -32768, 0, 32767, -32768));
    add_directed(mk(-32768, 32767, -32768, 32767, -32768, 32767, 32767));
    add_directed(mk(-1, 0, 0, 0, -1, 0, 0));
    add_directed(mk(-1, -1, 1, -1, 1, 1, -1));
    add_directed(mk(11585, 11585, 0, -11585, 11585, 0, 0));
    add_directed(mk(-11585, -11585, 16384, 0, 0, 0, 0));
    add_directed(mk(-16384, 1, -16384, 0, 0, 0, 0));
    add_directed(mk(16'h5555, 16'h2aaa, 16'h5555, 16'h2aaa, 16'h5555, 16'h2aaa,
                    16'h5555));
    foreach (directed_set[i]) send_matrix(directed_set[i], 1'b1);
    for (int n = 0; n < N_RANDOM; n++) begin
      if ($urandom_range(0, 3) == 0) send_matrix(rand_noise(), 1'b1);
      else send_matrix(rand_rotation(), 1'b1);
    end
    in_ch.valid <= 1'b0;
    sending_done = 1'b1;
  end

  // Receiver: random stalls per result, a long hold-off early on to fill the block.
  initial begin
    int wait_n;
    int taken;
    angles_t got;
    taken = 0;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (taken == 30) wait_n = 200;
      else wait_n = $urandom_range(0, 5);
      if (wait_n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got.yaw = out_ch.yaw_angle;
      got.pitch = out_ch.pitch_angle;
      got.roll = out_ch.roll_angle;
      board.check_angles(got);
      taken++;
    end
  end

  // Watchdog: counts cycles with no transaction on either channel.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // End of run: wait for every expected result, then let the pipeline drain a while.
  initial begin
    wait (sending_done);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (2 * PIPE_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
